[sv/bitmap_page_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Bitmap page allocator assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define BPA_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define BPA_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

[sv/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Field widths, command codes, word types and controller/datapath signals.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int CMD_W   = 1;
    localparam int COUNT_W = 11;
    localparam int START_W = 10;
    localparam int PAGE_W  = 10;
    localparam int FREE_W  = 11;
    localparam int ACT_W   = 11;

    localparam logic [CMD_W-1:0]  CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0]  CMD_FREE  = 1'b1;

    localparam logic [ACT_W-1:0]  ACTIVE_PAGES_RST = 11'd1024;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COUNT_W-1:0] page_count;
        logic [START_W-1:0] start_page;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [PAGE_W-1:0]  result_page;
        logic [FREE_W-1:0]  free_count;
    } rsp_t;

    typedef struct packed {
        logic init_en;
        logic load;
        logic mod_en;
        logic scan_en;
        logic mark_en;
        logic free_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic init_last;
        logic req_free;
        logic req_trivial;
        logic mod_done;
        logic found;
        logic scan_fail;
        logic mark_last;
        logic free_end;
    } ctrl_sts_t;

endpackage

[sv/bitmap_page_allocator.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Next-fit contiguous page allocator over a one-bit-per-page usage map.
// ----------------------------------------------------------------------------
// After reset the block sweeps the usage map to all-used, one page per cycle,
// holding busy high until the sweep ends. A word is taken when start is high
// and busy is low; its result appears on rsp with done high for exactly one
// cycle, and must be captured then. The usage map is a bit memory with one
// write port and one read port, read one page per cycle, which sets the
// timing. An allocate first brings the saved pointer below the active count,
// then scans at most active count + N pages for a free run of the N pages
// asked for and marks it. A free clears its run page by page, stopping early
// when the run passes the last active page. Zero-length allocates and
// allocates with an active count of zero finish without a scan.
`include "bitmap_page_allocator_defines.svh"

module bitmap_page_allocator #(
    parameter int NUM_PAGES = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bpa_pkg::ACT_W-1:0] cfg_wdata,
    input  logic                      start,
    input  bpa_pkg::req_t             req,
    output logic                      busy,
    output logic                      done,
    output bpa_pkg::rsp_t             rsp
);
    import bpa_pkg::*;

    ctrl_cmd_t ctl;
    ctrl_sts_t sts;

    bpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    bpa_datapath #(
        .NUM_PAGES (NUM_PAGES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .ctl       (ctl),
        .sts       (sts),
        .rsp       (rsp)
    );

    `BPA_ASSERT_NEXT(a_done_then_idle, done, !busy, "strobe not followed by idle")
    `BPA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted word left idle")
    `BPA_ASSERT_SAME(a_fail_page_zero, done && !rsp.ok, rsp.result_page == '0, "page on fail")
    `BPA_ASSERT_SAME(a_scan_exclusive, sts.found, ctl.scan_en && !sts.scan_fail, "stray hit")

endmodule

[sv/bpa_datapath.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator datapath
// Usage map memory, free counter, next-fit pointer and the scan/mark/free logic.
// ----------------------------------------------------------------------------
module bpa_datapath #(
    parameter int NUM_PAGES = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bpa_pkg::ACT_W-1:0] cfg_wdata,
    input  bpa_pkg::req_t             req,
    input  bpa_pkg::ctrl_cmd_t        ctl,
    output bpa_pkg::ctrl_sts_t        sts,
    output bpa_pkg::rsp_t             rsp
);
    import bpa_pkg::*;

    localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam int W  = (CW > 12) ? CW : 12;
    localparam int SW = W + 1;
    localparam int PW = (AW > PAGE_W) ? AW : PAGE_W;
    localparam int FW = (CW > FREE_W) ? CW : FREE_W;

    logic                 map_mem [NUM_PAGES];
    logic                 rd_data_reg;

    logic [ACT_W-1:0]     active_pages_reg;
    logic [CW-1:0]        free_cnt_reg;
    logic [CW-1:0]        next_start_reg;
    logic [AW-1:0]        init_idx_reg;
    logic [COUNT_W-1:0]   n_reg;
    logic [COUNT_W-1:0]   cnt_reg;
    logic [CW-1:0]        base_reg;
    logic [AW-1:0]        q_reg;
    logic [AW-1:0]        eval_reg;
    logic                 rd_vld_reg;
    logic [CW-1:0]        run_reg;
    logic                 pass_reg;
    logic [W-1:0]         ptr_reg;
    logic                 ok_reg;
    logic [AW-1:0]        page_reg;

    logic [CW-1:0]        a_eff;
    logic                 eval_ok;
    logic [CW-1:0]        run_base;
    logic [CW-1:0]        run_new;
    logic                 hit;
    logic                 at_end;
    logic                 past;
    logic [SW-1:0]        hit_start;
    logic [AW-1:0]        q_next;
    logic                 free_end;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_wdata;
    logic [PW-1:0]        page_ext;
    logic [FW-1:0]        cnt_ext;

    // effective page count: register clamped to the map size
    always_comb
    begin
        if (W'(active_pages_reg) > W'(NUM_PAGES))
            a_eff = CW'(NUM_PAGES);
        else
            a_eff = CW'(active_pages_reg);
    end

    // scan: data of page eval_reg arrives in the cycle after its read was issued
    assign eval_ok   = ctl.scan_en && rd_vld_reg;
    assign run_base  = (eval_reg == '0) ? '0 : run_reg;
    assign run_new   = rd_data_reg ? '0 : run_base + CW'(1);
    assign hit       = eval_ok && !rd_data_reg && (W'(run_base) + W'(1) == W'(n_reg));
    assign at_end    = (W'(eval_reg) + W'(1) == W'(a_eff));
    // after the wrap, a run ending here would start at or past the base
    assign past      = pass_reg && (SW'(eval_reg) + SW'(1) >= SW'(base_reg) + SW'(n_reg));
    assign hit_start = SW'(eval_reg) + SW'(1) - SW'(n_reg);
    assign q_next    = (W'(q_reg) + W'(1) == W'(a_eff)) ? '0 : q_reg + AW'(1);
    assign free_end  = (cnt_reg == '0) || (ptr_reg >= W'(a_eff));

    always_comb
    begin
        sts.init_last   = (init_idx_reg == AW'(NUM_PAGES - 1));
        sts.req_free    = (req.cmd == CMD_FREE);
        sts.req_trivial = (req.page_count == '0) || (a_eff == '0);
        sts.mod_done    = (base_reg < a_eff);
        sts.found       = hit;
        sts.scan_fail   = eval_ok && !hit &&
                          ((at_end && ((base_reg == '0) || pass_reg)) || past);
        sts.mark_last   = (cnt_reg == COUNT_W'(1));
        sts.free_end    = free_end;
    end

    // single write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg[AW-1:0];
        mem_wdata = 1'b1;
        if (ctl.init_en)
        begin
            mem_we    = 1'b1;
            mem_waddr = init_idx_reg;
        end
        else if (ctl.mark_en)
        begin
            mem_we    = 1'b1;
        end
        else if (ctl.free_en && !free_end)
        begin
            mem_we    = 1'b1;
            mem_wdata = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= map_mem[q_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_pages_reg <= ACTIVE_PAGES_RST;
            free_cnt_reg     <= '0;
            next_start_reg   <= '0;
            init_idx_reg     <= '0;
            rd_vld_reg       <= 1'b0;
            pass_reg         <= 1'b0;
            run_reg          <= '0;
            ok_reg           <= 1'b0;
            page_reg         <= '0;
        end
        else
        begin
            rd_vld_reg <= ctl.scan_en;
            if (cfg_we)
                active_pages_reg <= cfg_wdata;
            if (ctl.init_en)
                init_idx_reg <= init_idx_reg + AW'(1);
            if (ctl.load)
            begin
                ok_reg   <= (req.cmd == CMD_FREE);
                page_reg <= '0;
            end
            if (ctl.mod_en)
            begin
                run_reg  <= '0;
                pass_reg <= 1'b0;
            end
            if (eval_ok)
            begin
                run_reg <= run_new;
                if (at_end)
                    pass_reg <= 1'b1;
                if (hit)
                begin
                    ok_reg         <= 1'b1;
                    page_reg       <= hit_start[AW-1:0];
                    next_start_reg <= CW'(eval_reg) + CW'(1);
                end
            end
            if (ctl.mark_en && (free_cnt_reg != '0))
                free_cnt_reg <= free_cnt_reg - CW'(1);
            if (ctl.free_en)
            begin
                if (!free_end)
                begin
                    if (free_cnt_reg != CW'(NUM_PAGES))
                        free_cnt_reg <= free_cnt_reg + CW'(1);
                end
                else if (cnt_reg != '0)
                begin
                    ok_reg <= 1'b0;
                end
            end
        end
    end

    // work registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            n_reg    <= req.page_count;
            cnt_reg  <= req.page_count;
            ptr_reg  <= W'(req.start_page);
            base_reg <= next_start_reg;
        end
        if (ctl.mod_en)
        begin
            if (base_reg >= a_eff)
                base_reg <= base_reg - a_eff;
            q_reg <= base_reg[AW-1:0];
        end
        if (ctl.scan_en)
        begin
            q_reg    <= q_next;
            eval_reg <= q_reg;
        end
        if (hit)
        begin
            ptr_reg <= W'(hit_start);
            cnt_reg <= n_reg;
        end
        if (ctl.mark_en || (ctl.free_en && !free_end))
        begin
            ptr_reg <= ptr_reg + W'(1);
            cnt_reg <= cnt_reg - COUNT_W'(1);
        end
    end

    assign page_ext = PW'(page_reg);
    assign cnt_ext  = FW'(free_cnt_reg);

    always_comb
    begin
        rsp.ok          = ok_reg;
        rsp.result_page = page_ext[PAGE_W-1:0];
        rsp.free_count  = cnt_ext[FREE_W-1:0];
    end

endmodule

[sv/bpa_ctrl.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator controller
// Sequences map init, pointer wrap, scan, mark and free phases.
// ----------------------------------------------------------------------------
module bpa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  bpa_pkg::ctrl_sts_t  sts,
    output bpa_pkg::ctrl_cmd_t  ctl,
    output logic                busy,
    output logic                done
);
    import bpa_pkg::*;

    typedef enum logic [6:0] {
        ST_INIT = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_MOD  = 7'b0000100,
        ST_SCAN = 7'b0001000,
        ST_MARK = 7'b0010000,
        ST_FREE = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
                if (sts.init_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (start)
                begin
                    if (sts.req_free)
                        state_next = ST_FREE;
                    else if (sts.req_trivial)
                        state_next = ST_DONE;
                    else
                        state_next = ST_MOD;
                end
            ST_MOD:
                if (sts.mod_done)
                    state_next = ST_SCAN;
            ST_SCAN:
                if (sts.found)
                    state_next = ST_MARK;
                else if (sts.scan_fail)
                    state_next = ST_DONE;
            ST_MARK:
                if (sts.mark_last)
                    state_next = ST_DONE;
            ST_FREE:
                if (sts.free_end)
                    state_next = ST_DONE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        ctl.init_en = (state_reg == ST_INIT);
        ctl.load    = (state_reg == ST_IDLE) && start;
        ctl.mod_en  = (state_reg == ST_MOD);
        ctl.scan_en = (state_reg == ST_SCAN);
        ctl.mark_en = (state_reg == ST_MARK);
        ctl.free_en = (state_reg == ST_FREE);
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

[tb/bitmap_page_allocator_tb.sv]
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Sends allocate and free words through the start/busy handshake and checks
// every result word against a next-fit allocator kept inside the testbench.
// Directed tests cover reset state, range limits and the active-count
// extremes. Random phases then run well-formed allocate/free traffic with
// some noise, across several active-count settings and sender idle rates.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;
    import bpa_pkg::*;

    localparam int NPAGES         = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int MAX_PRINTED    = 40;

    typedef struct {
        int unsigned first;
        int unsigned len;
    } run_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [ACT_W-1:0]  cfg_wdata = '0;
    logic              start     = 1'b0;
    req_t              req       = '0;
    logic              busy;
    logic              done;
    rsp_t              rsp;

    // allocator state mirrored by the testbench
    logic [NPAGES-1:0] page_map;
    int unsigned       mirror_free;
    int unsigned       scan_ptr;
    int unsigned       managed_pages;

    rsp_t              awaited_rsp[$];
    rsp_t              want;
    run_t              live_runs[$];

    int                idle_pct;
    int                mismatches;
    int                stall_cycles;
    int                words_sent;
    int                grants;
    int                refusals;
    int                cfg_writes;

    bitmap_page_allocator #(
        .NUM_PAGES (NPAGES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int unsigned clamp_pages(int unsigned act);
        return (act > NPAGES) ? NPAGES : act;
    endfunction

    // Applies one word to the mirrored state and returns its result word.
    function automatic rsp_t apply_request(req_t w);
        rsp_t        r;
        int unsigned lim;
        int unsigned n;
        int unsigned base;
        int unsigned pos;
        int unsigned p;
        bit          fits;
        r   = '0;
        lim = clamp_pages(managed_pages);
        n   = 32'(w.page_count);
        if (w.cmd == CMD_ALLOC)
        begin
            if (n != 0 && lim != 0)
            begin
                base = scan_ptr % lim;
                for (int i = 0; i < lim && !r.ok; i++)
                begin
                    pos = (base + i) % lim;
                    if (pos + n <= lim)
                    begin
                        fits = 1'b1;
                        for (int j = 0; j < n && fits; j++)
                            if (page_map[pos + j])
                                fits = 1'b0;
                        if (fits)
                        begin
                            for (int j = 0; j < n; j++)
                            begin
                                page_map[pos + j] = 1'b1;
                                if (mirror_free > 0)
                                    mirror_free--;
                            end
                            scan_ptr      = pos + n;
                            r.ok          = 1'b1;
                            r.result_page = PAGE_W'(pos);
                            live_runs.push_back('{first: pos, len: n});
                        end
                    end
                end
            end
        end
        else
        begin
            r.ok = 1'b1;
            for (int j = 0; j < n; j++)
            begin
                p = w.start_page + j;
                if (p < lim)
                begin
                    page_map[p] = 1'b0;
                    if (mirror_free < NPAGES)
                        mirror_free++;
                end
                else
                    r.ok = 1'b0;
            end
        end
        r.free_count = FREE_W'(mirror_free);
        return r;
    endfunction

    // result word checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_rsp.size() == 0)
                report_mismatch("result word with nothing outstanding");
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.ok !== want.ok)
                    report_mismatch($sformatf("ok got %0b want %0b", rsp.ok, want.ok));
                if (rsp.result_page !== want.result_page)
                    report_mismatch($sformatf("result_page got %0d want %0d",
                                              rsp.result_page, want.result_page));
                if (rsp.free_count !== want.free_count)
                    report_mismatch($sformatf("free_count got %0d want %0d",
                                              rsp.free_count, want.free_count));
            end
        end
    end

    // watchdog: cycles with neither a word taken nor a result
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d stalled cycles", stall_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // start stays high across back-to-back words; only an idle gap or wait_results_drained lowers it
    task automatic send_word(req_t w);
        rsp_t r;
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(8, 40)) @(negedge clk);
            else
                repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start <= 1'b1;
        req   <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        r = apply_request(w);
        awaited_rsp.push_back(r);
        words_sent++;
        if (w.cmd == CMD_ALLOC)
        begin
            if (r.ok)
                grants++;
            else
                refusals++;
        end
    endtask

    task automatic send_cmd(logic [CMD_W-1:0] c, int unsigned cnt, int unsigned sp);
        req_t w;
        w.cmd        = c;
        w.page_count = COUNT_W'(cnt);
        w.start_page = START_W'(sp);
        send_word(w);
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_rsp.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic write_active(logic [ACT_W-1:0] v);
        wait_results_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        managed_pages = 32'(v);
        cfg_writes++;
    endtask

    // map is all used after reset: allocates fail, empty free is a no-op
    task automatic test_after_reset();
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_ALLOC, 0, 0);
        send_cmd(CMD_FREE, 0, 0);
        send_cmd(CMD_ALLOC, 2047, 1023);
    endtask

    // frees that run past the end, counter saturation at the top
    task automatic test_free_bounds();
        send_cmd(CMD_FREE, 2, 1023);
        send_cmd(CMD_FREE, 1024, 0);
        send_cmd(CMD_FREE, 1, 1023);
        send_cmd(CMD_FREE, 2047, 512);
    endtask

    task automatic test_alloc_runs();
        send_cmd(CMD_ALLOC, 1024, 0);
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_FREE, 1024, 0);
        // pointer sits at the active count and wraps to zero
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_ALLOC, 1023, 0);
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_FREE, 3, 5);
        send_cmd(CMD_ALLOC, 3, 0);
        send_cmd(CMD_FREE, 1024, 0);
        send_cmd(CMD_ALLOC, 2047, 0);
    endtask

    task automatic test_active_limits();
        write_active(11'd0);
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_FREE, 1, 0);
        write_active(11'd2047);
        send_cmd(CMD_ALLOC, 8, 0);
        send_cmd(CMD_ALLOC, 700, 0);
        // pointer left well past a small active count
        write_active(11'd1);
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_FREE, 1, 0);
        write_active(11'd16);
        send_cmd(CMD_ALLOC, 2, 0);
        write_active(ACTIVE_PAGES_RST);
        send_cmd(CMD_FREE, 1024, 1023);
    endtask

    task automatic run_random_phase(int words, logic [ACT_W-1:0] act);
        int unsigned lim;
        int unsigned pick;
        int unsigned k;
        run_t        run;
        write_active(act);
        lim = clamp_pages(32'(act));
        repeat (words)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                if ($urandom_range(19) == 0 && lim > 0)
                    send_cmd(CMD_ALLOC, $urandom_range(1, lim), $urandom_range(1023));
                else
                    send_cmd(CMD_ALLOC,
                             $urandom_range(1, (lim > 16) ? lim / 8 : 2),
                             $urandom_range(1023));
            end
            else if (pick < 85 && live_runs.size() > 0)
            begin
                k   = $urandom_range(live_runs.size() - 1);
                run = live_runs[k];
                live_runs.delete(k);
                send_cmd(CMD_FREE, run.len, run.first);
            end
            else
                send_cmd(CMD_W'($urandom_range(1)),
                         $urandom_range(0, 1100),
                         $urandom_range(1023));
        end
    endtask

    initial
    begin
        logic [ACT_W-1:0] act_plan [3][4];
        int               phase_idle [3];
        act_plan   = '{'{11'd1024, 11'd64, 11'd9, 11'd1500},
                       '{11'd37, 11'd1, 11'd512, 11'd0},
                       '{11'd200, 11'd2047, 11'd16, 11'd1024}};
        phase_idle = '{12, 54, 0};
        page_map      = '1;
        mirror_free   = 0;
        scan_ptr      = 0;
        managed_pages = ACTIVE_PAGES_RST;
        idle_pct      = 0;
        mismatches    = 0;
        words_sent    = 0;
        grants        = 0;
        refusals      = 0;
        cfg_writes    = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_free_bounds();
        test_alloc_runs();
        test_active_limits();

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = phase_idle[ph];
            for (int c = 0; c < 4; c++)
                run_random_phase(46, act_plan[ph][c]);
        end

        wait_results_drained();
        repeat (16) @(posedge clk);
        if (awaited_rsp.size() != 0)
            report_mismatch($sformatf("%0d result words never arrived", awaited_rsp.size()));

        $display("Sent %0d words over %0d active-count writes (0 through 2047).",
                 words_sent, cfg_writes);
        $display("Allocates granted %0d, refused %0d; %0d mismatches.",
                 grants, refusals, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_datapath.sv
sv/bpa_ctrl.sv
sv/bitmap_page_allocator.sv
tb/bitmap_page_allocator_tb.sv
